FILE: rtl/bmls_pkg.sv
// shared types, constants and codes of the bucketed member list store
package bmls_pkg;

   // fixed field widths
   localparam int unsigned CMD_W       = 2;
   localparam int unsigned BUCKET_ID_W = 4;
   localparam int unsigned MEMBER_W    = 10;
   localparam int unsigned STATUS_W    = 2;
   localparam int unsigned COUNT_W     = 5;
   localparam int unsigned LOC_W       = 5;

   // stream payload widths, padded to whole bytes
   localparam int unsigned REQ_DATA_W = 16;
   localparam int unsigned RSP_DATA_W = 24;

   // number of distinct bucket_id codes on the port
   localparam int unsigned BUCKET_ID_CODES = 1 << BUCKET_ID_W;

   // parameter defaults
   localparam int unsigned NUM_BUCKETS_DEF     = 16;
   localparam int unsigned BUCKET_CAPACITY_DEF = 16;

   // location reported after a successful remove (-1)
   localparam logic [LOC_W-1:0] LOC_REMOVED = '1;

   typedef enum logic [CMD_W-1:0] {
      CMD_ADD    = 2'd0,
      CMD_REMOVE = 2'd1,
      CMD_QUERY  = 2'd2
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_FULL      = 2'd1,
      STATUS_EMPTY     = 2'd2,
      STATUS_NOT_FOUND = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      STATE_CLEAR,
      STATE_IDLE,
      STATE_EXEC
   } state_type;

   // control outcome of one row edit
   typedef struct packed {
      status_type status;
      logic       changed;
      logic       removed;
   } edit_ctrl_type;

endpackage

FILE: rtl/bmls_row_edit.sv
// row edit: append or compacting delete on one bucket row, with count updates
module bmls_row_edit #(
   parameter int unsigned BUCKET_CAPACITY = bmls_pkg::BUCKET_CAPACITY_DEF,
   localparam int unsigned CNT_W = $clog2(BUCKET_CAPACITY + 1)
) (
   input  logic [bmls_pkg::CMD_W-1:0]                          cmd,
   input  logic [bmls_pkg::MEMBER_W-1:0]                       member_id,
   input  logic                                                member_flag,
   input  logic [BUCKET_CAPACITY-1:0][bmls_pkg::MEMBER_W-1:0]  slots_in,
   input  logic [CNT_W-1:0]                                    fill_in,
   input  logic [CNT_W-1:0]                                    flagged_in,
   output logic [BUCKET_CAPACITY-1:0][bmls_pkg::MEMBER_W-1:0]  slots_out,
   output logic [CNT_W-1:0]                                    fill_out,
   output logic [CNT_W-1:0]                                    flagged_out,
   output bmls_pkg::edit_ctrl_type                             ctrl
);

   logic [BUCKET_CAPACITY-1:0][bmls_pkg::MEMBER_W-1:0] slots_up;
   logic [BUCKET_CAPACITY-1:0][bmls_pkg::MEMBER_W-1:0] slots_add;
   logic [BUCKET_CAPACITY-1:0][bmls_pkg::MEMBER_W-1:0] slots_del;
   logic [BUCKET_CAPACITY-1:0]                         match;
   logic [BUCKET_CAPACITY-1:0]                         at_or_after;
   logic                                               found;

   // every slot shifted down by one place
   assign slots_up = slots_in >> bmls_pkg::MEMBER_W;

   // parallel compare over the live slots
   always_comb begin
      for (int i = 0; i < BUCKET_CAPACITY; i++) begin
         match[i] = (slots_in[i] == member_id) && (CNT_W'(i) < fill_in);
      end
   end

   // mark the first hit and everything behind it
   always_comb begin
      logic seen;
      seen = 1'b0;
      for (int i = 0; i < BUCKET_CAPACITY; i++) begin
         seen           = seen | match[i];
         at_or_after[i] = seen;
      end
   end

   assign found = |match;

   // append at the fill position, compact over the hit
   always_comb begin
      for (int i = 0; i < BUCKET_CAPACITY; i++) begin
         slots_add[i] = (CNT_W'(i) == fill_in) ? member_id : slots_in[i];
         slots_del[i] = at_or_after[i] ? slots_up[i] : slots_in[i];
      end
   end

   // command decode and count updates
   always_comb begin
      slots_out    = slots_in;
      fill_out     = fill_in;
      flagged_out  = flagged_in;
      ctrl.status  = bmls_pkg::STATUS_OK;
      ctrl.changed = 1'b0;
      ctrl.removed = 1'b0;
      unique case (bmls_pkg::cmd_type'(cmd))
         bmls_pkg::CMD_ADD: begin
            if (fill_in >= CNT_W'(BUCKET_CAPACITY)) begin
               ctrl.status = bmls_pkg::STATUS_FULL;
            end else begin
               slots_out    = slots_add;
               fill_out     = fill_in + CNT_W'(1);
               ctrl.changed = 1'b1;
               if (member_flag && (flagged_in < CNT_W'(BUCKET_CAPACITY))) begin
                  flagged_out = flagged_in + CNT_W'(1);
               end
            end
         end
         bmls_pkg::CMD_REMOVE: begin
            if (fill_in == '0) begin
               ctrl.status = bmls_pkg::STATUS_EMPTY;
            end else if (!found) begin
               ctrl.status = bmls_pkg::STATUS_NOT_FOUND;
            end else begin
               slots_out    = slots_del;
               fill_out     = fill_in - CNT_W'(1);
               ctrl.changed = 1'b1;
               ctrl.removed = 1'b1;
               if (member_flag && (flagged_in != '0)) begin
                  flagged_out = flagged_in - CNT_W'(1);
               end
            end
         end
         default: begin
            // query and the unused code: report only
            ctrl.status = bmls_pkg::STATUS_OK;
         end
      endcase
   end

endmodule

FILE: rtl/bucketed_member_list_store_core.sv
// top level of the bucketed member list store: row memory, sequencer, result register
//
// Each request beat carries a command (add, remove or query) for one bucket.
// Every bucket is one row of a synchronous memory holding its member ids in
// order together with its member count and flagged count. A request beat is
// accepted on req_tvalid & req_tready; the row is read in that cycle, then edited
// and written back once the output register is free, and the response beat
// lands in the output register, which drives rsp_tvalid.
// Each item is a read of the row memory followed by its write.
// req_tready is high only while no item is in flight, so a new beat is not taken
// before the last one has been written back.
// When the receiver holds rsp_tready low, one response waits in the output
// register while the next request is still taken and its row read; that item
// then waits before write-back until the output register frees up.
// After reset the memory is swept to zero, one bucket per cycle, and req_tready
// stays low until the whole sweep is done.
// A bucket_id at or above NUM_BUCKETS selects bucket bucket_id mod NUM_BUCKETS.
module bucketed_member_list_store_core #(
   parameter int unsigned NUM_BUCKETS     = bmls_pkg::NUM_BUCKETS_DEF,
   parameter int unsigned BUCKET_CAPACITY = bmls_pkg::BUCKET_CAPACITY_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // request: bucket_id[3:0], member_id[13:4], member_flag[14], zero pad
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [bmls_pkg::REQ_DATA_W-1:0]   req_tdata,
   // request kind: cmd[1:0]
   input  logic [bmls_pkg::CMD_W-1:0]        req_tuser,
   // response: status[1:0], member_count[6:2], flagged_count[11:7],
   // member_location[16:12], zero pad
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [bmls_pkg::RSP_DATA_W-1:0]   rsp_tdata
);

   localparam int unsigned BIDX_W = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
   localparam int unsigned CNT_W  = $clog2(BUCKET_CAPACITY + 1);
   localparam int unsigned SLOTS_W = BUCKET_CAPACITY * bmls_pkg::MEMBER_W;
   localparam int unsigned ROW_W  = SLOTS_W + 2 * CNT_W;
   localparam int unsigned RSP_USED_W = bmls_pkg::STATUS_W + 2 * bmls_pkg::COUNT_W
                                        + bmls_pkg::LOC_W;

   // request field split
   logic [bmls_pkg::BUCKET_ID_W-1:0] req_bucket_id;
   logic [bmls_pkg::MEMBER_W-1:0]    req_member_id;
   logic                             req_member_flag;

   assign req_bucket_id   = req_tdata[bmls_pkg::BUCKET_ID_W-1:0];
   assign req_member_id   = req_tdata[bmls_pkg::BUCKET_ID_W +: bmls_pkg::MEMBER_W];
   assign req_member_flag = req_tdata[bmls_pkg::BUCKET_ID_W + bmls_pkg::MEMBER_W];

   // bucket_id to row index, folded at elaboration
   logic [BIDX_W-1:0] bidx_tbl [bmls_pkg::BUCKET_ID_CODES];

   for (genvar g = 0; g < bmls_pkg::BUCKET_ID_CODES; g++) begin : g_bidx
      assign bidx_tbl[g] = BIDX_W'(g % NUM_BUCKETS);
   end

   // sequencer state and captured item
   bmls_pkg::state_type              state_ff, state_in;
   logic [BIDX_W-1:0]                clr_ff, clr_in;
   logic [BIDX_W-1:0]                bidx_ff;
   logic [bmls_pkg::CMD_W-1:0]       cmd_ff;
   logic [bmls_pkg::BUCKET_ID_W-1:0] bucket_id_ff;
   logic [bmls_pkg::MEMBER_W-1:0]    member_id_ff;
   logic                             member_flag_ff;

   // output register
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [bmls_pkg::RSP_DATA_W-1:0]  rsp_data_ff, rsp_data_in;

   // memory ports
   logic [ROW_W-1:0]  row_mem [NUM_BUCKETS];
   logic [ROW_W-1:0]  rdata_ff;
   logic              mem_re;
   logic              mem_we;
   logic [BIDX_W-1:0] mem_waddr;
   logic [ROW_W-1:0]  mem_wdata;

   logic req_accept;
   logic commit;
   logic clear_last;

   // row edit signals
   logic [BUCKET_CAPACITY-1:0][bmls_pkg::MEMBER_W-1:0] slots_new;
   logic [CNT_W-1:0]          fill_new;
   logic [CNT_W-1:0]          flagged_new;
   bmls_pkg::edit_ctrl_type   edit_ctrl;
   logic [bmls_pkg::LOC_W-1:0] loc;

   assign req_accept = req_tvalid && req_tready;
   assign commit     = (state_ff == bmls_pkg::STATE_EXEC) && (!rsp_valid_ff || rsp_tready);
   assign clear_last = (clr_ff == BIDX_W'(NUM_BUCKETS - 1));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bmls_pkg::STATE_CLEAR: begin
            if (clear_last) state_in = bmls_pkg::STATE_IDLE;
         end
         bmls_pkg::STATE_IDLE: begin
            if (req_tvalid) state_in = bmls_pkg::STATE_EXEC;
         end
         bmls_pkg::STATE_EXEC: begin
            if (commit) state_in = bmls_pkg::STATE_IDLE;
         end
         default: state_in = bmls_pkg::STATE_CLEAR;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_tready = 1'b0;
      mem_we     = 1'b0;
      mem_waddr  = bidx_ff;
      mem_wdata  = {flagged_new, fill_new, slots_new};
      clr_in     = clr_ff;
      unique case (state_ff)
         bmls_pkg::STATE_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = '0;
            clr_in    = clr_ff + BIDX_W'(1);
         end
         bmls_pkg::STATE_IDLE: begin
            req_tready = 1'b1;
         end
         bmls_pkg::STATE_EXEC: begin
            mem_we = commit && edit_ctrl.changed;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   assign mem_re = req_accept;

   // state and clear counter registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bmls_pkg::STATE_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
      end
   end

   // capture the accepted item
   always_ff @(posedge clock) begin
      if (req_accept) begin
         bidx_ff        <= bidx_tbl[req_bucket_id];
         cmd_ff         <= req_tuser;
         bucket_id_ff   <= req_bucket_id;
         member_id_ff   <= req_member_id;
         member_flag_ff <= req_member_flag;
      end
   end

   // row memory: one write and one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) row_mem[mem_waddr] <= mem_wdata;
   end

   always_ff @(posedge clock) begin
      if (mem_re) rdata_ff <= row_mem[bidx_tbl[req_bucket_id]];
   end

   // edit the row that was read
   bmls_row_edit #(
      .BUCKET_CAPACITY (BUCKET_CAPACITY)
   ) u_row_edit (
      .cmd         (cmd_ff),
      .member_id   (member_id_ff),
      .member_flag (member_flag_ff),
      .slots_in    (rdata_ff[SLOTS_W-1:0]),
      .fill_in     (rdata_ff[SLOTS_W +: CNT_W]),
      .flagged_in  (rdata_ff[SLOTS_W + CNT_W +: CNT_W]),
      .slots_out   (slots_new),
      .fill_out    (fill_new),
      .flagged_out (flagged_new),
      .ctrl        (edit_ctrl)
   );

   // response beat assembly
   assign loc = edit_ctrl.removed ? bmls_pkg::LOC_REMOVED
                                  : bmls_pkg::LOC_W'(bucket_id_ff);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (commit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = bmls_pkg::RSP_DATA_W'({loc,
                                               bmls_pkg::COUNT_W'(flagged_new),
                                               bmls_pkg::COUNT_W'(fill_new),
                                               edit_ctrl.status});
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(bmls_pkg::RSP_DATA_W - RSP_USED_W){1'b0}},
                        rsp_data_ff[RSP_USED_W-1:0]};

endmodule

FILE: dv/tb.sv
// testbench for the bucketed member list store core: directed table, random episodes, self-check
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import bmls_pkg::*;

   localparam int NUM_B       = NUM_BUCKETS_DEF;
   localparam int CAP         = BUCKET_CAPACITY_DEF;
   localparam int MEMBER_MAX  = (1 << MEMBER_W) - 1;
   localparam int LONG_HOLD   = 300;
   localparam int SETTLE      = 20;
   localparam int CYCLE_LIMIT = 200000;

   // unused command code, the block treats it as a query
   localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

   typedef struct packed {
      status_type         status;
      logic [COUNT_W-1:0] count;
      logic [COUNT_W-1:0] flagged;
      logic [LOC_W-1:0]   loc;
   } access_rsp_type;

   typedef struct packed {
      logic [CMD_W-1:0]       cmd;
      logic [BUCKET_ID_W-1:0] bucket;
      logic [MEMBER_W-1:0]    member;
      logic                   flag;
      logic                   known;   // response typed in below
      access_rsp_type         rsp;
   } table_row_type;

   localparam access_rsp_type NO_RSP = '0;

   // directed table: empty buckets, extremes, duplicates, flag saturation at zero
   localparam table_row_type DIRECTED_OPS [25] = '{
      '{CMD_QUERY,  4'd0,  10'd0,    1'b0, 1'b1, '{STATUS_OK,        5'd0, 5'd0, 5'd0}},
      '{CMD_SPARE,  4'd15, 10'd1023, 1'b1, 1'b1, '{STATUS_OK,        5'd0, 5'd0, 5'd15}},
      '{CMD_REMOVE, 4'd3,  10'd5,    1'b0, 1'b1, '{STATUS_EMPTY,     5'd0, 5'd0, 5'd3}},
      '{CMD_ADD,    4'd0,  10'd0,    1'b0, 1'b1, '{STATUS_OK,        5'd1, 5'd0, 5'd0}},
      '{CMD_ADD,    4'd15, 10'd1023, 1'b1, 1'b1, '{STATUS_OK,        5'd1, 5'd1, 5'd15}},
      '{CMD_REMOVE, 4'd15, 10'd1023, 1'b1, 1'b1, '{STATUS_OK,        5'd0, 5'd0, LOC_REMOVED}},
      '{CMD_REMOVE, 4'd15, 10'd1023, 1'b0, 1'b1, '{STATUS_EMPTY,     5'd0, 5'd0, 5'd15}},
      '{CMD_REMOVE, 4'd0,  10'd1023, 1'b0, 1'b1, '{STATUS_NOT_FOUND, 5'd1, 5'd0, 5'd0}},
      '{CMD_REMOVE, 4'd0,  10'd0,    1'b1, 1'b1, '{STATUS_OK,        5'd0, 5'd0, LOC_REMOVED}},
      '{CMD_ADD,    4'd7,  10'd341,  1'b1, 1'b0, NO_RSP},
      '{CMD_ADD,    4'd7,  10'd682,  1'b0, 1'b0, NO_RSP},
      '{CMD_ADD,    4'd7,  10'd341,  1'b1, 1'b0, NO_RSP},
      '{CMD_ADD,    4'd7,  10'd512,  1'b1, 1'b0, NO_RSP},
      '{CMD_QUERY,  4'd7,  10'd0,    1'b0, 1'b0, NO_RSP},
      '{CMD_REMOVE, 4'd7,  10'd341,  1'b0, 1'b0, NO_RSP},
      '{CMD_QUERY,  4'd7,  10'd1023, 1'b1, 1'b0, NO_RSP},
      '{CMD_REMOVE, 4'd7,  10'd341,  1'b1, 1'b0, NO_RSP},
      '{CMD_REMOVE, 4'd7,  10'd341,  1'b1, 1'b0, NO_RSP},
      '{CMD_REMOVE, 4'd7,  10'd682,  1'b1, 1'b0, NO_RSP},
      '{CMD_REMOVE, 4'd7,  10'd512,  1'b1, 1'b0, NO_RSP},
      '{CMD_REMOVE, 4'd7,  10'd1,    1'b1, 1'b0, NO_RSP},
      '{CMD_ADD,    4'd8,  10'd1,    1'b1, 1'b0, NO_RSP},
      '{CMD_REMOVE, 4'd8,  10'd1,    1'b0, 1'b0, NO_RSP},
      '{CMD_REMOVE, 4'd8,  10'd1,    1'b1, 1'b0, NO_RSP},
      '{CMD_ADD,    4'd8,  10'd2,    1'b0, 1'b0, NO_RSP}
   };

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic [CMD_W-1:0]      req_tuser  = '0;
   logic                  rsp_tready = 1'b0;
   logic                  req_tready;
   logic                  rsp_tvalid;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   // shadow copy of the bucket lists and counters
   logic [MEMBER_W-1:0] shadow_ids [NUM_B][CAP];
   int                  shadow_fill [NUM_B];
   int                  shadow_flagged [NUM_B];

   access_rsp_type rsp_queue [$];
   int          items_sent   = 0;
   int          fail_count   = 0;
   int          rsp_seen     = 0;
   int          status_tally [4] = '{0, 0, 0, 0};
   bit          req_gaps     = 1'b1;
   bit          rsp_idling   = 1'b1;
   bit          hold_request = 1'b0;

   bucketed_member_list_store_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   // apply one access to the shadow lists and return the response it yields
   function automatic access_rsp_type apply_access(input logic [CMD_W-1:0] cmd,
                                                   input logic [BUCKET_ID_W-1:0] bucket,
                                                   input logic [MEMBER_W-1:0] member,
                                                   input logic flag);
      access_rsp_type r;
      int b;
      int fill;
      int hit;
      int i;
      b = int'(bucket) % NUM_B;
      fill = shadow_fill[b];
      hit = -1;
      r.status = STATUS_OK;
      r.loc = {1'b0, bucket};
      if (cmd == CMD_ADD) begin
         if (fill >= CAP) begin
            r.status = STATUS_FULL;
         end else begin
            shadow_ids[b][fill] = member;
            shadow_fill[b] = fill + 1;
            if (flag && shadow_flagged[b] < CAP) shadow_flagged[b]++;
         end
      end else if (cmd == CMD_REMOVE) begin
         if (fill == 0) begin
            r.status = STATUS_EMPTY;
         end else begin
            // first match only
            for (i = 0; i < fill; i++)
               if (hit < 0 && shadow_ids[b][i] == member) hit = i;
            if (hit < 0) begin
               r.status = STATUS_NOT_FOUND;
            end else begin
               for (i = hit; i < fill - 1; i++)
                  shadow_ids[b][i] = shadow_ids[b][i + 1];
               shadow_fill[b] = fill - 1;
               if (flag && shadow_flagged[b] > 0) shadow_flagged[b]--;
               r.loc = LOC_REMOVED;
            end
         end
      end
      r.count = COUNT_W'(shadow_fill[b]);
      r.flagged = COUNT_W'(shadow_flagged[b]);
      return r;
   endfunction

   // offer one request beat, record its expected response once taken
   task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [BUCKET_ID_W-1:0] bucket,
                            input logic [MEMBER_W-1:0] member, input logic flag,
                            input logic known = 1'b0, input access_rsp_type typed = '0);
      access_rsp_type predicted;
      req_tvalid <= 1'b1;
      req_tuser <= cmd;
      req_tdata <= {1'b0, flag, member, bucket};
      do @(posedge clock); while (req_tready !== 1'b1);
      predicted = apply_access(cmd, bucket, member, flag);
      rsp_queue.push_back(known ? typed : predicted);
      items_sent++;
      if (req_gaps && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   endtask

   task automatic send_noise();
      send_item(CMD_W'($urandom_range(0, 3)), BUCKET_ID_W'($urandom_range(0, NUM_B - 1)),
                MEMBER_W'($urandom_range(0, MEMBER_MAX)), 1'($urandom_range(0, 1)));
   endtask

   // stop offering and wait for every outstanding response
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (rsp_queue.size() != 0);
   endtask

   // random episodes: fill to capacity, drain to empty, churn on a small id pool, noise
   task automatic run_random(input int n_items, input bit idle_ok);
      int stop;
      int kind;
      int pick;
      logic [BUCKET_ID_W-1:0] b;
      logic [CMD_W-1:0] op;
      logic [MEMBER_W-1:0] pool [4];
      logic all_flagged;
      stop = items_sent + n_items;
      while (items_sent < stop) begin
         kind = $urandom_range(0, 9);
         b = BUCKET_ID_W'($urandom_range(0, NUM_B - 1));
         req_gaps = idle_ok && ($urandom_range(0, 9) < 7);
         rsp_idling = idle_ok && ($urandom_range(0, 9) < 7);
         foreach (pool[i]) pool[i] = MEMBER_W'($urandom_range(0, MEMBER_MAX));
         if (kind < 2) begin
            // fill up, overflow, then trade an unflagged removal for a flagged add
            all_flagged = 1'($urandom_range(0, 1));
            while (shadow_fill[b] < CAP)
               send_item(CMD_ADD, b, MEMBER_W'($urandom_range(0, MEMBER_MAX)),
                         all_flagged | 1'($urandom_range(0, 1)));
            repeat ($urandom_range(1, 3))
               send_item(CMD_ADD, b, MEMBER_W'($urandom_range(0, MEMBER_MAX)),
                         1'($urandom_range(0, 1)));
            pick = $urandom_range(0, CAP - 1);
            send_item(CMD_REMOVE, b, shadow_ids[b][pick], 1'b0);
            send_item(CMD_ADD, b, MEMBER_W'($urandom_range(0, MEMBER_MAX)), 1'b1);
         end else if (kind < 4) begin
            // drain, mostly by ids that are present, then remove from the empty bucket
            while (shadow_fill[b] > 0) begin
               pick = $urandom_range(0, shadow_fill[b] - 1);
               if ($urandom_range(0, 4) != 0)
                  send_item(CMD_REMOVE, b, shadow_ids[b][pick], 1'($urandom_range(0, 1)));
               else
                  send_item(CMD_REMOVE, b, MEMBER_W'($urandom_range(0, MEMBER_MAX)),
                            1'($urandom_range(0, 1)));
            end
            repeat ($urandom_range(1, 2))
               send_item(CMD_REMOVE, b, MEMBER_W'($urandom_range(0, MEMBER_MAX)),
                         1'($urandom_range(0, 1)));
         end else if (kind < 9) begin
            // small id pool so duplicates and hits are common
            repeat ($urandom_range(12, 30)) begin
               pick = $urandom_range(0, 19);
               if (pick < 8) op = CMD_ADD;
               else if (pick < 16) op = CMD_REMOVE;
               else if (pick < 19) op = CMD_QUERY;
               else op = CMD_SPARE;
               send_item(op, b ^ BUCKET_ID_W'($urandom_range(0, 1)),
                         pool[$urandom_range(0, 3)], 1'($urandom_range(0, 1)));
            end
         end else begin
            repeat (8) send_noise();
         end
      end
   endtask

   // response side: random stall bursts, one long hold on request
   initial begin : rsp_side
      @(posedge clock);
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else if (rsp_idling && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // compare each response beat with the oldest expectation
   always @(posedge clock) begin : rsp_check
      access_rsp_type got;
      access_rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.status = status_type'(rsp_tdata[1:0]);
         got.count = rsp_tdata[6:2];
         got.flagged = rsp_tdata[11:7];
         got.loc = rsp_tdata[16:12];
         rsp_seen++;
         status_tally[got.status]++;
         if (rsp_queue.size() == 0) begin
            $display("%0t unexpected response beat, expected none, got %h", $time, rsp_tdata);
            fail_count++;
         end else begin
            want = rsp_queue.pop_front();
            if (got.status !== want.status || got.count !== want.count ||
                got.flagged !== want.flagged || got.loc !== want.loc) begin
               $display("%0t mismatch: expected status %0d count %0d flagged %0d loc %0d",
                        $time, want.status, want.count, want.flagged, want.loc);
               $display("%0t          got status %0d count %0d flagged %0d loc %0d",
                        $time, got.status, got.count, got.flagged, got.loc);
               fail_count++;
            end
         end
      end
   end

   // cycle limit
   initial begin : watchdog
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("status: fail");
      $finish;
   end

   initial begin : stimulus
      foreach (shadow_fill[i]) begin
         shadow_fill[i] = 0;
         shadow_flagged[i] = 0;
      end
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed table
      foreach (DIRECTED_OPS[i])
         send_item(DIRECTED_OPS[i].cmd, DIRECTED_OPS[i].bucket, DIRECTED_OPS[i].member,
                   DIRECTED_OPS[i].flag, DIRECTED_OPS[i].known, DIRECTED_OPS[i].rsp);

      run_random(500, 1'b1);

      // pause until drained, then back up the block behind a long response hold
      wait_drained();
      req_gaps = 1'b0;
      rsp_idling = 1'b0;
      hold_request = 1'b1;
      repeat (40) send_noise();
      wait_drained();

      run_random(400, 1'b1);
      // closing stretch without idling
      run_random(175, 1'b0);
      wait_drained();
      repeat (SETTLE) @(posedge clock);

      $display("%0d requests over add, remove, query and the spare code; %0d responses",
               items_sent, rsp_seen);
      $display("responses ok %0d, full %0d, empty %0d, not found %0d; one %0d-cycle hold",
               status_tally[STATUS_OK], status_tally[STATUS_FULL], status_tally[STATUS_EMPTY],
               status_tally[STATUS_NOT_FOUND], LONG_HOLD);
      if (fail_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

FILE: bucketed_member_list_store_core.f
rtl/bmls_pkg.sv
rtl/bmls_row_edit.sv
rtl/bucketed_member_list_store_core.sv
dv/tb.sv
